// File: sv/dct_coefficient_vlc_decoder_defines.svh
// Assertion macros shared by the DCT coefficient decoder RTL.
`ifndef DCT_COEFFICIENT_VLC_DECODER_DEFINES_SVH
`define DCT_COEFFICIENT_VLC_DECODER_DEFINES_SVH

// Checked only while the block is out of reset.
`define DCVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, including during reset.
`define DCVD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/dcvd_pkg.sv
// Types, status codes and the coefficient code table of the DCT coefficient decoder.
`default_nettype none
package dcvd_pkg;

  typedef enum logic [1:0] {
    ST_PAIR    = 2'd0,
    ST_EOB     = 2'd1,
    ST_SHORT   = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  localparam int VLC_COUNT = 112;
  localparam logic [4:0] LONGEST_CODE = 5'd16;

  typedef struct packed {
    logic [7:0] code;
    logic [4:0] len;
    logic [5:0] run;
    logic [5:0] mag;
    logic       esc;
  } vlc_entry_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] len;
    logic [5:0] run;
    logic [5:0] mag;
    logic       esc;
  } vlc_hit_t;

  localparam vlc_entry_t VLC_TABLE [VLC_COUNT] = '{
    '{8'h03, 5'd2, 6'd0, 6'd1, 1'b0},   '{8'h03, 5'd3, 6'd1, 6'd1, 1'b0},
    '{8'h04, 5'd4, 6'd0, 6'd2, 1'b0},   '{8'h05, 5'd4, 6'd2, 6'd1, 1'b0},
    '{8'h05, 5'd5, 6'd0, 6'd3, 1'b0},   '{8'h07, 5'd5, 6'd3, 6'd1, 1'b0},
    '{8'h06, 5'd5, 6'd4, 6'd1, 1'b0},   '{8'h06, 5'd6, 6'd1, 6'd2, 1'b0},
    '{8'h07, 5'd6, 6'd5, 6'd1, 1'b0},   '{8'h05, 5'd6, 6'd6, 6'd1, 1'b0},
    '{8'h04, 5'd6, 6'd7, 6'd1, 1'b0},   '{8'h01, 5'd6, 6'd0, 6'd0, 1'b1},
    '{8'h06, 5'd7, 6'd0, 6'd4, 1'b0},   '{8'h04, 5'd7, 6'd2, 6'd2, 1'b0},
    '{8'h07, 5'd7, 6'd8, 6'd1, 1'b0},   '{8'h05, 5'd7, 6'd9, 6'd1, 1'b0},
    '{8'h26, 5'd8, 6'd0, 6'd5, 1'b0},   '{8'h21, 5'd8, 6'd0, 6'd6, 1'b0},
    '{8'h25, 5'd8, 6'd1, 6'd3, 1'b0},   '{8'h24, 5'd8, 6'd3, 6'd2, 1'b0},
    '{8'h27, 5'd8, 6'd10, 6'd1, 1'b0},  '{8'h23, 5'd8, 6'd11, 6'd1, 1'b0},
    '{8'h22, 5'd8, 6'd12, 6'd1, 1'b0},  '{8'h20, 5'd8, 6'd13, 6'd1, 1'b0},
    '{8'h0A, 5'd10, 6'd0, 6'd7, 1'b0},  '{8'h0C, 5'd10, 6'd1, 6'd4, 1'b0},
    '{8'h0B, 5'd10, 6'd2, 6'd3, 1'b0},  '{8'h0F, 5'd10, 6'd4, 6'd2, 1'b0},
    '{8'h09, 5'd10, 6'd5, 6'd2, 1'b0},  '{8'h0E, 5'd10, 6'd14, 6'd1, 1'b0},
    '{8'h0D, 5'd10, 6'd15, 6'd1, 1'b0}, '{8'h08, 5'd10, 6'd16, 6'd1, 1'b0},
    '{8'h1D, 5'd12, 6'd0, 6'd8, 1'b0},  '{8'h18, 5'd12, 6'd0, 6'd9, 1'b0},
    '{8'h13, 5'd12, 6'd0, 6'd10, 1'b0}, '{8'h10, 5'd12, 6'd0, 6'd11, 1'b0},
    '{8'h1B, 5'd12, 6'd1, 6'd5, 1'b0},  '{8'h14, 5'd12, 6'd2, 6'd4, 1'b0},
    '{8'h1C, 5'd12, 6'd3, 6'd3, 1'b0},  '{8'h12, 5'd12, 6'd4, 6'd3, 1'b0},
    '{8'h1E, 5'd12, 6'd6, 6'd2, 1'b0},  '{8'h15, 5'd12, 6'd7, 6'd2, 1'b0},
    '{8'h11, 5'd12, 6'd8, 6'd2, 1'b0},  '{8'h1F, 5'd12, 6'd17, 6'd1, 1'b0},
    '{8'h1A, 5'd12, 6'd18, 6'd1, 1'b0}, '{8'h19, 5'd12, 6'd19, 6'd1, 1'b0},
    '{8'h17, 5'd12, 6'd20, 6'd1, 1'b0}, '{8'h16, 5'd12, 6'd21, 6'd1, 1'b0},
    '{8'h1A, 5'd13, 6'd0, 6'd12, 1'b0}, '{8'h19, 5'd13, 6'd0, 6'd13, 1'b0},
    '{8'h18, 5'd13, 6'd0, 6'd14, 1'b0}, '{8'h17, 5'd13, 6'd0, 6'd15, 1'b0},
    '{8'h16, 5'd13, 6'd1, 6'd6, 1'b0},  '{8'h15, 5'd13, 6'd1, 6'd7, 1'b0},
    '{8'h14, 5'd13, 6'd2, 6'd5, 1'b0},  '{8'h13, 5'd13, 6'd3, 6'd4, 1'b0},
    '{8'h12, 5'd13, 6'd5, 6'd3, 1'b0},  '{8'h11, 5'd13, 6'd9, 6'd2, 1'b0},
    '{8'h10, 5'd13, 6'd10, 6'd2, 1'b0}, '{8'h1F, 5'd13, 6'd22, 6'd1, 1'b0},
    '{8'h1E, 5'd13, 6'd23, 6'd1, 1'b0}, '{8'h1D, 5'd13, 6'd24, 6'd1, 1'b0},
    '{8'h1C, 5'd13, 6'd25, 6'd1, 1'b0}, '{8'h1B, 5'd13, 6'd26, 6'd1, 1'b0},
    '{8'h1F, 5'd14, 6'd0, 6'd16, 1'b0}, '{8'h1E, 5'd14, 6'd0, 6'd17, 1'b0},
    '{8'h1D, 5'd14, 6'd0, 6'd18, 1'b0}, '{8'h1C, 5'd14, 6'd0, 6'd19, 1'b0},
    '{8'h1B, 5'd14, 6'd0, 6'd20, 1'b0}, '{8'h1A, 5'd14, 6'd0, 6'd21, 1'b0},
    '{8'h19, 5'd14, 6'd0, 6'd22, 1'b0}, '{8'h18, 5'd14, 6'd0, 6'd23, 1'b0},
    '{8'h17, 5'd14, 6'd0, 6'd24, 1'b0}, '{8'h16, 5'd14, 6'd0, 6'd25, 1'b0},
    '{8'h15, 5'd14, 6'd0, 6'd26, 1'b0}, '{8'h14, 5'd14, 6'd0, 6'd27, 1'b0},
    '{8'h13, 5'd14, 6'd0, 6'd28, 1'b0}, '{8'h12, 5'd14, 6'd0, 6'd29, 1'b0},
    '{8'h11, 5'd14, 6'd0, 6'd30, 1'b0}, '{8'h10, 5'd14, 6'd0, 6'd31, 1'b0},
    '{8'h18, 5'd15, 6'd0, 6'd32, 1'b0}, '{8'h17, 5'd15, 6'd0, 6'd33, 1'b0},
    '{8'h16, 5'd15, 6'd0, 6'd34, 1'b0}, '{8'h15, 5'd15, 6'd0, 6'd35, 1'b0},
    '{8'h14, 5'd15, 6'd0, 6'd36, 1'b0}, '{8'h13, 5'd15, 6'd0, 6'd37, 1'b0},
    '{8'h12, 5'd15, 6'd0, 6'd38, 1'b0}, '{8'h11, 5'd15, 6'd0, 6'd39, 1'b0},
    '{8'h10, 5'd15, 6'd0, 6'd40, 1'b0}, '{8'h1F, 5'd15, 6'd1, 6'd8, 1'b0},
    '{8'h1E, 5'd15, 6'd1, 6'd9, 1'b0},  '{8'h1D, 5'd15, 6'd1, 6'd10, 1'b0},
    '{8'h1C, 5'd15, 6'd1, 6'd11, 1'b0}, '{8'h1B, 5'd15, 6'd1, 6'd12, 1'b0},
    '{8'h1A, 5'd15, 6'd1, 6'd13, 1'b0}, '{8'h19, 5'd15, 6'd1, 6'd14, 1'b0},
    '{8'h13, 5'd16, 6'd1, 6'd15, 1'b0}, '{8'h12, 5'd16, 6'd1, 6'd16, 1'b0},
    '{8'h11, 5'd16, 6'd1, 6'd17, 1'b0}, '{8'h10, 5'd16, 6'd1, 6'd18, 1'b0},
    '{8'h14, 5'd16, 6'd6, 6'd3, 1'b0},  '{8'h1A, 5'd16, 6'd11, 6'd2, 1'b0},
    '{8'h19, 5'd16, 6'd12, 6'd2, 1'b0}, '{8'h18, 5'd16, 6'd13, 6'd2, 1'b0},
    '{8'h17, 5'd16, 6'd14, 6'd2, 1'b0}, '{8'h16, 5'd16, 6'd15, 6'd2, 1'b0},
    '{8'h15, 5'd16, 6'd16, 6'd2, 1'b0}, '{8'h1F, 5'd16, 6'd27, 6'd1, 1'b0},
    '{8'h1E, 5'd16, 6'd28, 6'd1, 1'b0}, '{8'h1D, 5'd16, 6'd29, 6'd1, 1'b0},
    '{8'h1C, 5'd16, 6'd30, 6'd1, 1'b0}, '{8'h1B, 5'd16, 6'd31, 6'd1, 1'b0}
  };

endpackage
`default_nettype wire

// File: sv/dcvd_cfg.sv
// Configuration register file holding the escape level mode.
`default_nettype none
module dcvd_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             mpeg2_mode
);
  import dcvd_pkg::*;

  logic mpeg2_mode_r;
  logic mpeg2_mode_nxt;
  logic wr_en;

  // The single register occupies the whole word, so every byte offset selects it.
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    mpeg2_mode_nxt = mpeg2_mode_r;
    if (wr_en) begin
      mpeg2_mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpeg2_mode_r <= 1'b1;
    end else begin
      mpeg2_mode_r <= mpeg2_mode_nxt;
    end
  end

  assign pready     = 1'b1;
  assign prdata     = (paddr[1:0] == 2'b00) ? {31'd0, mpeg2_mode_r} : {31'd0, mpeg2_mode_r};
  assign mpeg2_mode = mpeg2_mode_r;

endmodule
`default_nettype wire

// File: sv/dcvd_lookup.sv
// Parallel prefix match of the leading window bits against the coefficient code table.
`default_nettype none
module dcvd_lookup (
  input  wire logic [15:0] prefix,
  output dcvd_pkg::vlc_hit_t match
);
  import dcvd_pkg::*;

  // The table is a prefix code, so at most one entry matches and the fields can be ORed.
  always_comb begin
    match = '0;
    for (int k = 0; k < VLC_COUNT; k++) begin
      if ((prefix >> (LONGEST_CODE - VLC_TABLE[k].len)) == {8'h00, VLC_TABLE[k].code}) begin
        match.hit = 1'b1;
        match.len = match.len | VLC_TABLE[k].len;
        match.run = match.run | VLC_TABLE[k].run;
        match.mag = match.mag | VLC_TABLE[k].mag;
        match.esc = match.esc | VLC_TABLE[k].esc;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/dct_coefficient_vlc_decoder.sv
// Top level of the DCT coefficient VLC decoder: request register, decode and result register.
// An accepted request is held in the request register, and its result is shown with
// out_valid from the result register. Requests are taken only while busy is low.
// Throughput: one request per cycle; the code table match sits between the two registers.
// Reset: synchronous, active low; busy is high while in reset, the result strobe is
// cleared and mpeg2_mode returns to 1. The receiver cannot stall results.
`default_nettype none
module dct_coefficient_vlc_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_bit_window,
  input  wire logic [5:0]  in_bits_valid,
  input  wire logic        in_first_coefficient,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [5:0]       out_run,
  output logic signed [11:0] out_level,
  output logic [4:0]       out_bits_used,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import dcvd_pkg::*;
  `include "dct_coefficient_vlc_decoder_defines.svh"

  logic        busy_r;
  logic        req_valid_r;
  logic [31:0] window_r;
  logic [5:0]  bits_valid_r;
  logic        first_r;

  logic              res_valid_r;
  status_t           status_r;
  logic [5:0]        run_r;
  logic [11:0]       level_r;
  logic [4:0]        used_r;

  status_t     status_nxt;
  logic [5:0]  run_nxt;
  logic [11:0] level_nxt;
  logic [4:0]  used_nxt;

  logic        mpeg2_mode;
  vlc_hit_t    match;
  logic [5:0]  avail;
  logic [5:0]  code_len;
  logic        sign_bit;
  logic [7:0]  esc_b;
  logic [7:0]  esc_b2;
  logic        accept;

  dcvd_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .mpeg2_mode (mpeg2_mode)
  );

  dcvd_lookup u_lookup (
    .prefix (window_r[31:16]),
    .match  (match)
  );

  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      req_valid_r <= accept;
      res_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window_r     <= in_bit_window;
      bits_valid_r <= in_bits_valid;
      first_r      <= in_first_coefficient;
    end
    if (req_valid_r) begin
      status_r <= status_nxt;
      run_r    <= run_nxt;
      level_r  <= level_nxt;
      used_r   <= used_nxt;
    end
  end

  assign avail    = (bits_valid_r > 6'd32) ? 6'd32 : bits_valid_r;
  assign code_len = {1'b0, match.len};
  assign sign_bit = window_r[5'd31 - match.len];
  assign esc_b    = window_r[19:12];
  assign esc_b2   = window_r[11:4];

  always_comb begin
    status_nxt = ST_SHORT;
    run_nxt    = 6'd0;
    level_nxt  = 12'd0;
    used_nxt   = 5'd0;
    if (avail == 6'd0) begin
      status_nxt = ST_SHORT;
    end else if (first_r && window_r[31]) begin
      if (avail >= 6'd2) begin
        status_nxt = ST_PAIR;
        level_nxt  = window_r[30] ? 12'hFFF : 12'h001;
        used_nxt   = 5'd2;
      end
    end else if (!first_r && (avail < 6'd2)) begin
      status_nxt = ST_SHORT;
    end else if (!first_r && (window_r[31:30] == 2'b10)) begin
      status_nxt = ST_EOB;
      used_nxt   = 5'd2;
    end else if (!match.hit) begin
      status_nxt = (avail < 6'd16) ? ST_SHORT : ST_NOMATCH;
    end else if (code_len > avail) begin
      status_nxt = ST_SHORT;
    end else if (!match.esc) begin
      if ((code_len + 6'd1) <= avail) begin
        status_nxt = ST_PAIR;
        run_nxt    = match.run;
        level_nxt  = sign_bit ? (12'd0 - {6'd0, match.mag}) : {6'd0, match.mag};
        used_nxt   = match.len + 5'd1;
      end
    end else if (mpeg2_mode) begin
      // Escape: six-bit run, then a 12-bit two's complement level.
      if (avail >= 6'd24) begin
        status_nxt = ST_PAIR;
        run_nxt    = window_r[25:20];
        level_nxt  = window_r[19:8];
        used_nxt   = 5'd24;
      end
    end else begin
      // Escape in the older form: an 8-bit level, or a marker byte and a second byte.
      if ((esc_b == 8'h00) || (esc_b == 8'h80)) begin
        if (avail >= 6'd28) begin
          status_nxt = ST_PAIR;
          run_nxt    = window_r[25:20];
          level_nxt  = {{4{esc_b[7]}}, esc_b2};
          used_nxt   = 5'd28;
        end
      end else if (avail >= 6'd20) begin
        status_nxt = ST_PAIR;
        run_nxt    = window_r[25:20];
        level_nxt  = {{4{esc_b[7]}}, esc_b};
        used_nxt   = 5'd20;
      end
    end
  end

  assign busy          = busy_r;
  assign out_valid     = res_valid_r;
  assign out_status    = status_r;
  assign out_run       = run_r;
  assign out_level     = level_r;
  assign out_bits_used = used_r;

  `DCVD_ASSERT(a_result_follows_request, accept |-> ##2 out_valid, "request lost in pipeline")
  `DCVD_ASSERT(a_unused_fields_zero, out_valid && (out_status == ST_SHORT || out_status == ST_NOMATCH) |-> (out_bits_used == 5'd0) && (out_run == 6'd0) && (out_level == 12'd0), "fields not cleared on failure")
  `DCVD_ASSERT(a_eob_two_bits, out_valid && (out_status == ST_EOB) |-> (out_bits_used == 5'd2) && (out_level == 12'd0), "bad end of block result")
  `DCVD_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid && busy, "reset did not clear control")

endmodule
`default_nettype wire
